// ===== rtl/orlt_pkg.sv =====
package orlt_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [IDX_W-1:0]      t_idx;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_SEARCH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    // Broadcast control shared by every cell of the row.
    typedef struct packed {
        logic  fire;
        t_cmd  cmd;
        logic  full;
        t_data key;
    } t_cell_ctl;

endpackage

// ===== rtl/orlt_cell.sv =====
module orlt_cell
    import orlt_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occupied,
    input  logic      i_at_tail,
    input  t_data     i_left,
    input  t_data     i_right,
    input  logic      i_found,
    output t_data     o_entry,
    output logic      o_found,
    output logic      o_first
);

    t_data r_entry;
    t_data n_entry;
    logic  w_match;

    assign w_match = i_occupied && (r_entry == i_ctl.key);
    assign o_found = i_found | w_match;
    assign o_first = w_match & ~i_found;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.fire) begin
            case (i_ctl.cmd)
                CMD_APPEND: begin
                    if (!i_ctl.full && i_at_tail) n_entry = i_ctl.key;
                end
                CMD_INSERT: begin
                    // shift up one place; cell 0 sees the key as its left neighbor
                    if (!i_ctl.full) n_entry = i_left;
                end
                CMD_DELETE: begin
                    // close the gap from the first match upward
                    if (o_found) n_entry = i_right;
                end
                default: begin
                    n_entry = r_entry;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== rtl/ordered_ring_list_table.sv =====
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_cmd, i_value
// output    out        o_valid / i_stall    o_status, o_index, o_count
//
// One word in, one word out per command. Once a command is accepted, its
// result stands in the output register at the next clock edge, so a new
// command can enter every cycle while results keep draining; the row of cells
// compares and shifts all entries at once, and the first-match chain through
// the row sets the cycle time. Reset clears the list length and the output
// valid; the entries themselves hold whatever was last written.
// Input stalls only while a result waits and the output side stalls.
module ordered_ring_list_table
    import orlt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [3:0]  o_index,
    output logic [4:0]  o_count
);

    logic      r_length_ok;
    t_cnt      r_length;
    t_cnt      n_length;
    logic      r_valid;
    logic [1:0] r_status;
    logic [3:0] r_index;
    logic [4:0] r_count;

    logic      w_accept;
    logic      w_full;
    t_cmd      w_cmd;
    t_data     w_key;
    logic [63:0] w_value_ext;
    t_cell_ctl w_ctl;
    t_status   w_status;
    t_idx      w_idx;
    logic [31:0] w_idx_ext;
    logic [31:0] w_cnt_ext;

    t_data              w_entry [CAPACITY];
    logic [CAPACITY:0]  w_found;
    logic [CAPACITY-1:0] w_first;

    // Hold the input while a result waits and the output side stalls.
    assign o_stall  = r_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    // Drop value bits above the stored data width.
    assign w_value_ext = {32'd0, i_value};
    assign w_key       = w_value_ext[DATA_WIDTH-1:0];
    assign w_cmd       = t_cmd'(i_cmd);
    assign w_full      = (r_length == t_cnt'(CAPACITY));

    assign w_ctl.fire = w_accept;
    assign w_ctl.cmd  = w_cmd;
    assign w_ctl.full = w_full;
    assign w_ctl.key  = w_key;

    // Row of cells: found ripples upward, data shifts to a neighbor.
    assign w_found[0] = 1'b0;
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_data w_left;
        t_data w_right;
        if (g == 0) begin : g_head
            assign w_left = w_key;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        orlt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occupied (r_length > t_cnt'(g)),
            .i_at_tail  (r_length == t_cnt'(g)),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_found    (w_found[g]),
            .o_entry    (w_entry[g]),
            .o_found    (w_found[g+1]),
            .o_first    (w_first[g])
        );
    end

    // Encode the single first-match position.
    always_comb begin
        w_idx = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (w_first[k]) w_idx = w_idx | t_idx'(k);
        end
    end

    // Work out status and the new length.
    always_comb begin
        w_status = ST_OK;
        n_length = r_length;
        case (w_cmd)
            CMD_APPEND, CMD_INSERT: begin
                if (w_full) w_status = ST_FULL;
                else        n_length = r_length + t_cnt'(1);
            end
            CMD_DELETE: begin
                if (w_found[CAPACITY]) n_length = r_length - t_cnt'(1);
                else                   w_status = ST_MISS;
            end
            default: begin
                if (!w_found[CAPACITY]) w_status = ST_MISS;
            end
        endcase
    end

    assign w_idx_ext = ((w_cmd == CMD_DELETE || w_cmd == CMD_SEARCH) && w_found[CAPACITY])
                       ? 32'(w_idx) : 32'd0;
    assign w_cnt_ext = 32'(n_length);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (w_accept) r_length <= n_length;
            r_valid <= w_accept | (r_valid & i_stall);
        end
    end

    // Result payload; load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_index  <= w_idx_ext[3:0];
            r_count  <= w_cnt_ext[4:0];
        end
    end

    assign r_length_ok = (r_length <= t_cnt'(CAPACITY));

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_index  = r_index;
    assign o_count  = r_count;

`ifndef ASSERT_OFF
    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_length_ok)
        else $error("list length beyond capacity");

    a_first_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one first match in the row");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_full && (w_cmd == CMD_APPEND || w_cmd == CMD_INSERT))
        |=> (r_length == $past(r_length) + t_cnt'(1)))
        else $error("insert did not grow the list");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_status == ST_FULL) |=> (r_length == t_cnt'(CAPACITY)))
        else $error("dropped insert changed the length");
`endif

endmodule
